[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define FNL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FNL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fnl_pkg.sv]
`timescale 1ns / 1ps

package fnl_pkg;

   localparam logic [31:0] LN2_BITS  = 32'h3F317218;
   localparam logic [31:0] SEED_BITS = 32'h3DBA2E8C;   // 1/11
   localparam logic [31:0] EXP_LSB   = 32'h0080_0000;

   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_STAGES    = 7;
   localparam int QUO_W         = DIV_STEP_BITS * DIV_STAGES;
   localparam int REM_W         = 25;
   localparam int POLY_STAGES   = 13;

   typedef struct packed {
      logic              vld;
      logic              zero;
      logic [REM_W-1:0]  rem;
      logic [REM_W-1:0]  dvs;
      logic [QUO_W-1:0]  quo;
      logic [4:0]        lz;
      logic [31:0]       ef;
   } div_stage_type;

   typedef struct packed {
      logic        vld;
      logic [31:0] t;
      logic [31:0] ef;
   } tq_type;

   typedef struct packed {
      logic        vld;
      logic [31:0] p;
      logic [31:0] t2;
      logic [31:0] b;
      logic [31:0] a;
   } poly_stage_type;

   function automatic logic [31:0] coef_bits(input logic [2:0] k);
      logic [31:0] c;
      case (k)
         3'd0:    c = 32'h3DE38E39;   // 1/9
         3'd1:    c = 32'h3E124925;   // 1/7
         3'd2:    c = 32'h3E4CCCCD;   // 1/5
         3'd3:    c = 32'h3EAAAAAB;   // 1/3
         default: c = 32'h3F800000;   // 1
      endcase
      return c;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = '0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) found = 1'b1;
            else n = n + 5'd1;
         end
      end
      return n;
   endfunction

   // Round to nearest even and pack; sig carries the hidden bit.
   function automatic logic [31:0] fp_pack(input logic s, input logic signed [9:0] ex,
                                           input logic [23:0] sig, input logic g,
                                           input logic st);
      logic              inc;
      logic [24:0]       rs;
      logic signed [9:0] ef;
      inc = g & (st | sig[0]);
      rs  = {1'b0, sig} + {24'd0, inc};
      ef  = ex;
      if (rs[24]) ef = ex + 10'sd1;
      return {s, ef[7:0], rs[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
      logic [47:0]       pr;
      logic signed [9:0] ex;
      logic              s;
      s  = x[31] ^ y[31];
      pr = {1'b1, x[22:0]} * {1'b1, y[22:0]};
      ex = $signed({2'b00, x[30:23]}) + $signed({2'b00, y[30:23]}) - 10'sd127;
      if (x[30:23] == 8'd0 || y[30:23] == 8'd0) return 32'd0;
      if (pr[47]) return fp_pack(s, ex + 10'sd1, pr[47:24], pr[23], |pr[22:0]);
      return fp_pack(s, ex, pr[46:23], pr[22], |pr[21:0]);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
      logic [31:0]       big;
      logic [31:0]       lit;
      logic [7:0]        d;
      logic [26:0]       mb;
      logic [26:0]       ml;
      logic [26:0]       sh;
      logic [27:0]       sm;
      logic [4:0]        lz;
      logic [26:0]       nm;
      logic signed [9:0] ex;
      logic              st;
      if (x[30:23] == 8'd0) return y;
      if (y[30:23] == 8'd0) return x;
      if (x[30:0] >= y[30:0]) begin
         big = x;
         lit = y;
      end else begin
         big = y;
         lit = x;
      end
      d  = big[30:23] - lit[30:23];
      mb = {1'b1, big[22:0], 3'b000};
      ml = {1'b1, lit[22:0], 3'b000};
      if (d >= 8'd27) begin
         sh = 27'd1;
      end else begin
         sh    = ml >> d;
         st    = |(ml & ((27'd1 << d) - 27'd1));
         sh[0] = sh[0] | st;
      end
      if (big[31] == lit[31]) sm = {1'b0, mb} + {1'b0, sh};
      else sm = {1'b0, mb} - {1'b0, sh};
      if (sm == 28'd0) return 32'd0;
      ex = $signed({2'b00, big[30:23]});
      if (sm[27]) return fp_pack(big[31], ex + 10'sd1, sm[27:4], sm[3], |sm[2:0]);
      lz = lzc27(sm[26:0]);
      nm = sm[26:0] << lz;
      return fp_pack(big[31], ex - $signed({5'd0, lz}), nm[26:3], nm[2], |nm[1:0]);
   endfunction

   function automatic logic [31:0] fp_from_int(input logic signed [8:0] e);
      logic [7:0] mg;
      logic [4:0] lz;
      logic [7:0] nm;
      logic [7:0] be;
      logic       s;
      s  = e[8];
      mg = s ? 8'(-e) : e[7:0];
      lz = lzc27({mg, 19'd0});
      nm = mg << lz[2:0];
      be = 8'd134 - {3'd0, lz};
      if (e == 9'sd0) return 32'd0;
      return {s, be, nm[6:0], 16'd0};
   endfunction

   // Four restoring divide steps.
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type o;
      logic          qb;
      o = s;
      for (int j = 0; j < DIV_STEP_BITS; j++) begin
         qb = (o.rem >= o.dvs);
         if (qb) o.rem = o.rem - o.dvs;
         o.rem = o.rem << 1;
         o.quo = {o.quo[QUO_W-2:0], qb};
      end
      return o;
   endfunction

endpackage

[hw/rtl/fnl_front.sv]
`timescale 1ns / 1ps

module fnl_front import fnl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [31:0]   operand_bits,
   output div_stage_type out_stg
);

   div_stage_type     stg_ff;
   div_stage_type     stg_in;
   logic [22:0]       frac;
   logic [4:0]        lz;
   logic [23:0]       base;
   logic              inc;
   logic signed [8:0] e;

   always_comb begin
      frac = operand_bits[22:0];
      lz   = lzc27({frac, 4'd0});
      // m + 1 lands in [2,3): drop one fraction bit, round to even
      base = {1'b1, 1'b0, frac[22:1]};
      inc  = frac[0] & frac[1];
      e    = $signed({1'b0, operand_bits[30:23]}) - 9'sd127;

      stg_in.vld  = in_valid;
      stg_in.zero = (frac == 23'd0);
      stg_in.rem  = {1'b0, 24'({frac, 1'b0} << lz)};
      stg_in.dvs  = {1'b0, base} + {24'd0, inc};
      stg_in.quo  = '0;
      stg_in.lz   = lz;
      stg_in.ef   = fp_from_int(e);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.vld <= 1'b0;
      end else if (adv) begin
         stg_ff <= stg_in;
      end
   end

   assign out_stg = stg_ff;

endmodule

[hw/rtl/fnl_div.sv]
`timescale 1ns / 1ps

module fnl_div import fnl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  div_stage_type in_stg,
   output tq_type        out_tq
);

   div_stage_type stg_ff [DIV_STAGES];
   div_stage_type stg_in [DIV_STAGES];
   div_stage_type last;
   tq_type        tq_ff;
   tq_type        tq_in;
   logic          sticky;

   always_comb begin
      stg_in[0] = div_step(in_stg);
      for (int i = 1; i < DIV_STAGES; i++) begin
         stg_in[i] = div_step(stg_ff[i-1]);
      end
   end

   // quotient holds N/D scaled by 2^27; its top bit picks the exponent
   always_comb begin
      last      = stg_ff[DIV_STAGES-1];
      sticky    = (last.rem != '0);
      tq_in.vld = last.vld;
      tq_in.ef  = last.ef;
      if (last.zero) begin
         tq_in.t = '0;
      end else if (last.quo[27]) begin
         tq_in.t = fp_pack(1'b0, 10'sd125 - $signed({5'd0, last.lz}), last.quo[27:4],
                           last.quo[3], (|last.quo[2:0]) | sticky);
      end else begin
         tq_in.t = fp_pack(1'b0, 10'sd124 - $signed({5'd0, last.lz}), last.quo[26:3],
                           last.quo[2], (|last.quo[1:0]) | sticky);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) stg_ff[i].vld <= 1'b0;
         tq_ff.vld <= 1'b0;
      end else if (adv) begin
         stg_ff <= stg_in;
         tq_ff  <= tq_in;
      end
   end

   assign out_tq = tq_ff;

endmodule

[hw/rtl/fnl_poly.sv]
`timescale 1ns / 1ps

module fnl_poly import fnl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  tq_type      in_tq,
   output logic        out_valid,
   output logic [31:0] out_bits
);

   poly_stage_type stg_ff [POLY_STAGES];
   poly_stage_type stg_in [POLY_STAGES];

   always_comb begin
      stg_in[0].vld = in_tq.vld;
      stg_in[0].p   = SEED_BITS;
      stg_in[0].t2  = fp_mul(in_tq.t, in_tq.t);
      stg_in[0].b   = (in_tq.t[30:23] == 8'd0) ? 32'd0 : in_tq.t + EXP_LSB;
      stg_in[0].a   = fp_mul(in_tq.ef, LN2_BITS);
      // odd stages multiply by t2, even stages add the next coefficient,
      // then 2t*p and the final add of e*ln2
      for (int i = 1; i < POLY_STAGES; i++) begin
         stg_in[i] = stg_ff[i-1];
         if (i == POLY_STAGES - 1) begin
            stg_in[i].p = fp_add(stg_ff[i-1].a, stg_ff[i-1].p);
         end else if (i == POLY_STAGES - 2) begin
            stg_in[i].p = fp_mul(stg_ff[i-1].b, stg_ff[i-1].p);
         end else if (i % 2 == 1) begin
            stg_in[i].p = fp_mul(stg_ff[i-1].p, stg_ff[i-1].t2);
         end else begin
            stg_in[i].p = fp_add(stg_ff[i-1].p, coef_bits(3'((i - 2) >> 1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POLY_STAGES; i++) stg_ff[i].vld <= 1'b0;
      end else if (adv) begin
         stg_ff <= stg_in;
      end
   end

   assign out_valid = stg_ff[POLY_STAGES-1].vld;
   assign out_bits  = stg_ff[POLY_STAGES-1].p;

endmodule

[hw/rtl/float_natural_log_series_core.sv]
`timescale 1ns / 1ps
// Natural log of an IEEE single by the atanh series, every operation rounded
// to nearest even on its own, so results match single-precision software.
// Input channel: req_valid / req_ready with req_operand_bits; the sign bit is
// ignored and zero, denormal, inf and NaN exponents are taken as raw fields.
// Result channel: rsp_valid / rsp_ready with rsp_log_bits, one beat per input.
// The pipeline has 1 unpack stage, 7 divider stages at 4 quotient bits
// each, 1 round stage for t, 13 stages for t*t, the Horner chain and the
// final multiply and add. Throughput is one beat per cycle unless stalled.
// The whole pipeline advances together: when rsp_valid is high and
// rsp_ready is low every stage holds and req_ready drops, so nothing is
// lost or repeated. Synchronous reset clears all valid bits; data
// registers are not reset.
module float_natural_log_series_core import fnl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_operand_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_log_bits
);

   logic          adv;
   div_stage_type front_stg;
   tq_type        div_tq;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   fnl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_valid),
      .operand_bits (req_operand_bits),
      .out_stg      (front_stg)
   );

   fnl_div u_div (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .in_stg (front_stg),
      .out_tq (div_tq)
   );

   fnl_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_tq     (div_tq),
      .out_valid (rsp_valid),
      .out_bits  (rsp_log_bits)
   );

endmodule

[hw/rtl/fnl_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fnl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_log_bits
);

   `FNL_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "rsp_valid after reset")
   `FNL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_log_bits), "stalled beat changed")
   `FNL_ASSERT(a_ready_follows, clock, reset, req_ready == (!rsp_valid || rsp_ready), "req_ready does not track stall")
   `FNL_ASSERT(a_finite, clock, reset, rsp_valid |-> rsp_log_bits[30:23] != 8'hFF, "result not finite")

endmodule

bind float_natural_log_series_core fnl_checker u_fnl_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   class log_scoreboard;
      logic [31:0] expected_log_q[$];
      int          errors;

      function new();
         errors = 0;
      endfunction

      // Round a real to single precision (nearest even), return its bit pattern.
      // Every value here stays in the normal range or is exactly zero.
      static function logic [31:0] to_single(real r);
         logic [63:0] d;
         logic [7:0]  ex;
         logic        g;
         logic        st;
         d = $realtobits(r);
         if (d[62:52] == 11'd0) return {d[63], 31'd0};
         ex = 8'(d[62:52] - 11'd1023 + 11'd127);
         g  = d[28];
         st = |d[27:0];
         return {d[63], ex, d[51:29]} + {31'd0, g & (st | d[29])};
      endfunction

      static function real from_single(logic [31:0] f);
         if (f[30:23] == 8'd0) return 0.0;
         return $bitstoreal({f[31], 11'(f[30:23]) - 11'd127 + 11'd1023, f[22:0], 29'd0});
      endfunction

      // One single-precision rounding step.
      static function real rnd(real r);
         return from_single(to_single(r));
      endfunction

      // Double holds every exact product and quotient well enough that a
      // second rounding to single is still correct.
      static function logic [31:0] ln_series(logic [31:0] x);
         int  e;
         real m;
         real t;
         real t2;
         real p;
         real a;
         real b;
         real c;
         real coef[5];
         e = int'(x[30:23]) - 127;
         m = from_single({9'h07F, x[22:0]});
         coef[0] = rnd(1.0 / 9.0);
         coef[1] = rnd(1.0 / 7.0);
         coef[2] = rnd(1.0 / 5.0);
         coef[3] = rnd(1.0 / 3.0);
         coef[4] = 1.0;
         t  = rnd(rnd(m - 1.0) / rnd(m + 1.0));
         t2 = rnd(t * t);
         p  = rnd(1.0 / 11.0);
         for (int k = 0; k < 5; k++) p = rnd(rnd(p * t2) + coef[k]);
         a = rnd(real'(e) * rnd(0.69314718056));
         b = rnd(2.0 * t);
         c = rnd(b * p);
         return to_single(a + c);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void note_operand(logic [31:0] x);
         expected_log_q.push_back(ln_series(x));
      endfunction

      task check_result(logic [31:0] y);
         logic [31:0] want;
         if (expected_log_q.size() == 0) begin
            report($sformatf("unexpected beat log_bits=%h", y));
         end else begin
            want = expected_log_q.pop_front();
            if (y !== want) report($sformatf("log_bits=%h want %h", y, want));
         end
      endtask
   endclass

   localparam int LATENCY   = 22;
   localparam int STALL_MAX = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_operand_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_log_bits;

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int stall_cycles      = 0;

   log_scoreboard sb = new();

   always #4 clock = ~clock;

   float_natural_log_series_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operand_bits (req_operand_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_log_bits     (rsp_log_bits)
   );

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom % 100) >= receiver_idle_pct;
   end

   // scoreboard taps and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_operand(req_operand_bits);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_log_bits);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
               $display("[float_natural_log_series_core] ERROR");
               $finish;
            end
         end
      end
   end

   task send_operand(input logic [31:0] x);
      while (($urandom % 100) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operand_bits <= x;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_log_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      logic [31:0] x;
      x = $urandom;
      case ($urandom % 4)
         0: x[30:23] = 8'($urandom_range(120, 134));
         1: x[22:0]  = ($urandom % 2) ? 23'h7FFFFF : 23'd0;
         default: ;
      endcase
      return x;
   endfunction

   logic [31:0] directed_ops[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000,
      32'hBF80_0000, 32'h7F80_0000, 32'h7FC0_0001, 32'h0000_0001, 32'h007F_FFFF,
      32'h0080_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h3F00_0000, 32'h7F7F_FFFF,
      32'h3FB5_04F3, 32'h402D_F854, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3F80_0001
   };

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 35;
      receiver_idle_pct = 80;
      foreach (directed_ops[i]) send_operand(directed_ops[i]);
      // hold off until the pipeline has emptied
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 35; receiver_idle_pct = 80; end
            1: begin sender_idle_pct = 80; receiver_idle_pct = 35; end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
         endcase
         for (int n = 0; n < 517; n++) send_operand(random_operand());
      end
      wait_drained();

      if (sb.expected_log_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_log_q.size()));
      if (sb.errors == 0) begin
         $display("[float_natural_log_series_core] OK");
      end else begin
         $display("[float_natural_log_series_core] ERROR");
      end
      $finish;
   end

endmodule
